>>> design/script_token_lexer_top_defines.svh
// Assertion macros shared by the lexer modules.
`ifndef SCRIPT_TOKEN_LEXER_TOP_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lexer assertion failed");

// Next-cycle implication, checked outside reset.
`define STL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lexer assertion failed");

`endif

>>> design/stl_pkg.sv
// Shared types, constants and character classes of the script token lexer.
package stl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_WORD,
        MODE_STRING,
        MODE_EQUALS
    } t_mode;

    typedef enum logic [1:0] {
        SLOT_END0,
        SLOT_TEXT,
        SLOT_END1
    } t_slot;

    localparam logic [3:0] KIND_DEF     = 4'd0;
    localparam logic [3:0] KIND_OUTPUT  = 4'd1;
    localparam logic [3:0] KIND_IF      = 4'd2;
    localparam logic [3:0] KIND_ELSE    = 4'd3;
    localparam logic [3:0] KIND_WHILE   = 4'd4;
    localparam logic [3:0] KIND_END     = 4'd5;
    localparam logic [3:0] KIND_TYPE    = 4'd6;
    localparam logic [3:0] KIND_ID      = 4'd7;
    localparam logic [3:0] KIND_NUMBER  = 4'd8;
    localparam logic [3:0] KIND_STRING  = 4'd9;
    localparam logic [3:0] KIND_SEMI    = 4'd10;
    localparam logic [3:0] KIND_COLON   = 4'd11;
    localparam logic [3:0] KIND_OP      = 4'd12;
    localparam logic [3:0] KIND_UNKNOWN = 4'd13;

    localparam logic [0:0] REC_TEXT = 1'b0;
    localparam logic [0:0] REC_END  = 1'b1;

    localparam int PREFIX_DEPTH = 6;
    localparam logic [2:0] LEN_MAX = 3'd7;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One queue entry: everything a single input request produces, in order.
    typedef struct packed {
        logic       has_end0;
        logic [3:0] kind0;
        logic       has_text;
        logic [7:0] text;
        logic       has_end1;
        logic [3:0] kind1;
    } t_cmd;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_word_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == "_");
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        return (b == "=") || (b == "/") || (b == "*") || (b == "-") ||
               (b == "+") || (b == ">") || (b == "<");
    endfunction

    // The first stored byte sits in the top byte of the packed prefix.
    function automatic logic [3:0] word_kind(input logic [47:0] p, input logic [2:0] len);
        logic [3:0] k;
        k = KIND_ID;
        if (len == 3'd3 && p[47:24] == "def") begin
            k = KIND_DEF;
        end else if (len == 3'd6 && p == "output") begin
            k = KIND_OUTPUT;
        end else if (len == 3'd2 && p[47:32] == "if") begin
            k = KIND_IF;
        end else if (len == 3'd4 && p[47:16] == "else") begin
            k = KIND_ELSE;
        end else if (len == 3'd5 && p[47:8] == "while") begin
            k = KIND_WHILE;
        end else if (len == 3'd3 && p[47:24] == "end") begin
            k = KIND_END;
        end else if (len == 3'd3 && (p[47:24] == "int" || p[47:24] == "str")) begin
            k = KIND_TYPE;
        end else if (len == 3'd5 && p[47:8] == "float") begin
            k = KIND_TYPE;
        end
        return k;
    endfunction

endpackage

>>> design/stl_front.sv
// Front end: accepts source bytes, tracks the lexing mode and builds queue entries.
module stl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_text_byte,
    input  logic          i_is_end,
    input  logic          i_q_full,
    output logic          o_push,
    output stl_pkg::t_cmd o_cmd
);
    import stl_pkg::*;

    t_mode      r_mode, n_mode;
    logic [2:0] r_len, n_len;
    logic [7:0] r_prefix [PREFIX_DEPTH];
    logic       pre_wr;
    logic [2:0] pre_idx;
    logic       acc;
    logic [3:0] pend_kind;
    t_cmd       cmd;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= 3'd0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && pre_wr) begin
            r_prefix[pre_idx] <= i_text_byte;
        end
    end

    always_comb begin
        pend_kind = KIND_OP;
        unique case (r_mode)
            MODE_NUMBER: pend_kind = KIND_NUMBER;
            MODE_WORD:   pend_kind = word_kind({r_prefix[0], r_prefix[1], r_prefix[2],
                                                r_prefix[3], r_prefix[4], r_prefix[5]},
                                               r_len);
            MODE_STRING: pend_kind = KIND_STRING;
            default:     pend_kind = KIND_OP;
        endcase
    end

    always_comb begin
        cmd      = '0;
        n_mode   = r_mode;
        n_len    = r_len;
        pre_wr   = 1'b0;
        pre_idx  = 3'd0;
        cmd.text = i_text_byte;
        priority if (i_is_end) begin
            cmd.has_end0 = (r_mode != MODE_IDLE);
            cmd.kind0    = pend_kind;
            n_mode       = MODE_IDLE;
        end else if (r_mode == MODE_STRING) begin
            if (i_text_byte == "\"") begin
                cmd.has_end0 = 1'b1;
                cmd.kind0    = KIND_STRING;
                n_mode       = MODE_IDLE;
            end else begin
                cmd.has_text = 1'b1;
            end
        end else if (r_mode == MODE_NUMBER &&
                     (is_digit(i_text_byte) || i_text_byte == ".")) begin
            cmd.has_text = 1'b1;
        end else if (r_mode == MODE_WORD && is_word_char(i_text_byte)) begin
            cmd.has_text = 1'b1;
            pre_wr       = (r_len < 3'(PREFIX_DEPTH));
            pre_idx      = r_len;
            if (r_len < LEN_MAX) begin
                n_len = r_len + 3'd1;
            end
        end else if (r_mode == MODE_EQUALS && i_text_byte == "=") begin
            cmd.has_text = 1'b1;
            cmd.has_end1 = 1'b1;
            cmd.kind1    = KIND_OP;
            n_mode       = MODE_IDLE;
        end else begin
            // Close whatever is pending, then treat the byte as new text.
            cmd.has_end0 = (r_mode != MODE_IDLE);
            cmd.kind0    = pend_kind;
            n_mode       = MODE_IDLE;
            priority if (is_space(i_text_byte)) begin
                cmd.has_text = 1'b0;
            end else if (i_text_byte == ";") begin
                cmd.has_text = 1'b1;
                cmd.has_end1 = 1'b1;
                cmd.kind1    = KIND_SEMI;
            end else if (i_text_byte == ":") begin
                cmd.has_text = 1'b1;
                cmd.has_end1 = 1'b1;
                cmd.kind1    = KIND_COLON;
            end else if (is_digit(i_text_byte)) begin
                cmd.has_text = 1'b1;
                n_mode       = MODE_NUMBER;
            end else if (i_text_byte == "\"") begin
                n_mode = MODE_STRING;
            end else if (is_alpha(i_text_byte) || i_text_byte == "_") begin
                cmd.has_text = 1'b1;
                pre_wr       = 1'b1;
                pre_idx      = 3'd0;
                n_len        = 3'd1;
                n_mode       = MODE_WORD;
            end else if (i_text_byte == "=") begin
                cmd.has_text = 1'b1;
                n_mode       = MODE_EQUALS;
            end else if (is_op(i_text_byte)) begin
                cmd.has_text = 1'b1;
                cmd.has_end1 = 1'b1;
                cmd.kind1    = KIND_OP;
            end else begin
                cmd.has_text = 1'b1;
                cmd.has_end1 = 1'b1;
                cmd.kind1    = KIND_UNKNOWN;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = acc && (cmd.has_end0 || cmd.has_text || cmd.has_end1);

endmodule

>>> design/stl_queue.sv
// Short queue of lexer commands between the front and back ends.
`include "script_token_lexer_top_defines.svh"
module stl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stl_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output stl_pkg::t_cmd o_cmd
);
    import stl_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `STL_ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))
    `STL_ASSERT_IMPL(a_q_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `STL_ASSERT_IMPL(a_q_push_room, i_clk, i_rst_n, i_push, !o_full)
    `STL_ASSERT_NEXT(a_q_grow, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QCNT_W'(1))

endmodule

>>> design/stl_back.sv
// Back end: walks the records of the head queue entry and presents them one at a time.
`include "script_token_lexer_top_defines.svh"
module stl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  stl_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_record_kind,
    output logic [3:0]    o_token_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_last
);
    import stl_pkg::*;

    t_slot r_slot, n_slot;
    t_slot cur;
    logic  later;
    logic  acc;

    // Pick the first record of the entry at or after the saved slot.
    always_comb begin
        priority if (r_slot == SLOT_END0 && i_cmd.has_end0) begin
            cur = SLOT_END0;
        end else if (r_slot != SLOT_END1 && i_cmd.has_text) begin
            cur = SLOT_TEXT;
        end else begin
            cur = SLOT_END1;
        end
    end

    always_comb begin
        later         = 1'b0;
        o_record_kind = REC_END;
        o_token_kind  = KIND_DEF;
        o_out_byte    = 8'd0;
        unique case (cur)
            SLOT_END0: begin
                later        = i_cmd.has_text || i_cmd.has_end1;
                o_token_kind = i_cmd.kind0;
            end
            SLOT_TEXT: begin
                later         = i_cmd.has_end1;
                o_record_kind = REC_TEXT;
                o_out_byte    = i_cmd.text;
            end
            default: begin
                later        = 1'b0;
                o_token_kind = i_cmd.kind1;
            end
        endcase
    end

    assign o_valid = i_q_valid;
    assign o_last  = !later;
    assign acc     = o_valid && i_ready;
    assign o_pop   = acc && !later;

    always_comb begin
        n_slot = r_slot;
        if (acc) begin
            if (!later) begin
                n_slot = SLOT_END0;
            end else begin
                unique case (cur)
                    SLOT_END0: n_slot = SLOT_TEXT;
                    default:   n_slot = SLOT_END1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_END0;
        end else begin
            r_slot <= n_slot;
        end
    end

    `STL_ASSERT_IMPL(a_b_present, i_clk, i_rst_n, o_valid, (cur == SLOT_END0 && i_cmd.has_end0) || (cur == SLOT_TEXT && i_cmd.has_text) || (cur == SLOT_END1 && i_cmd.has_end1))
    `STL_ASSERT_IMPL(a_b_text_kind, i_clk, i_rst_n, o_valid && o_record_kind == REC_TEXT, o_token_kind == KIND_DEF)
    `STL_ASSERT_IMPL(a_b_end_byte, i_clk, i_rst_n, o_valid && o_record_kind == REC_END, o_out_byte == 8'd0)
    `STL_ASSERT_NEXT(a_b_slot_rewind, i_clk, i_rst_n, o_pop, r_slot == SLOT_END0)

endmodule

>>> design/script_token_lexer_top.sv
// An accepted source byte enters the queue; its first record shows from the queue head,
// behind any entries already there. Throughput: one byte per cycle while each byte yields
// at most one record and i_ready is high; a byte with several records holds the output
// side, absorbed by a four-entry queue. Input ready drops only when that queue is full.
// Reset (synchronous, active low) returns to idle mode and empties the queue.
// Top level of the streaming script token lexer.
module script_token_lexer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_record_kind,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import stl_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    t_cmd push_cmd, head_cmd;

    stl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_is_end    (i_is_end),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (push_cmd)
    );

    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    stl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_record_kind (o_record_kind),
        .o_token_kind  (o_token_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

endmodule
